### rtl/pisp_pkg.sv
// shared types and constants of the panel init sequence player
package pisp_pkg;

  localparam logic [31:0] RELEASE_WORD = 32'h0ff0_0000;
  localparam int          QDEPTH       = 4;
  localparam int          QAW          = $clog2(QDEPTH);
  localparam int          NSLOT        = 9;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_DELAY = 2'd1,
    PH_REG   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WORD      = 2'd0,
    KIND_DELAY     = 2'd1,
    KIND_ONE_LINE  = 2'd2,
    KIND_FOUR_LINE = 2'd3
  } kind_t;

  // result slots in emission order
  typedef enum logic [3:0] {
    SLOT_ONE_LINE  = 4'd0,
    SLOT_FOUR_LINE = 4'd1,
    SLOT_REG_REL   = 4'd2,
    SLOT_CMD       = 4'd3,
    SLOT_ZERO_A    = 4'd4,
    SLOT_BYTE      = 4'd5,
    SLOT_ZERO_B    = 4'd6,
    SLOT_END_REL   = 4'd7,
    SLOT_DELAY     = 4'd8
  } slot_t;

  // one classified table byte: which results it causes
  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic [7:0]       data_byte;
    logic [10:0]      delay_ms;
  } q_entry_t;

endpackage

### rtl/pisp_front.sv
// front end: parses table bytes and classifies them into result masks
module pisp_front import pisp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] table_byte,
  output logic       push,
  output q_entry_t   entry
);

  phase_t     phase_r, phase_nxt;
  logic       start_r, start_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] delay_r, delay_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      start_r <= 1'b1;
      left_r  <= 8'd0;
      delay_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      left_r  <= left_nxt;
      delay_r <= delay_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    start_nxt       = start_r;
    left_nxt        = left_r;
    delay_nxt       = delay_r;
    entry.mask      = '0;
    entry.data_byte = table_byte;
    // five times the held delay byte
    entry.delay_ms  = {1'b0, delay_r, 2'b00} + {3'b000, delay_r};
    if (accept) begin
      case (phase_r)
        PH_COUNT: begin
          if (start_r) entry.mask[SLOT_ONE_LINE] = 1'b1;
          if (table_byte == 8'd0) begin
            entry.mask[SLOT_FOUR_LINE] = 1'b1;
            start_nxt = 1'b1;
          end else begin
            start_nxt = 1'b0;
            left_nxt  = table_byte - 8'd1;
            phase_nxt = PH_DELAY;
          end
        end
        PH_DELAY: begin
          delay_nxt = table_byte;
          phase_nxt = PH_REG;
        end
        PH_REG: begin
          entry.mask[SLOT_REG_REL] = 1'b1;
          entry.mask[SLOT_CMD]     = 1'b1;
          entry.mask[SLOT_ZERO_A]  = 1'b1;
          entry.mask[SLOT_BYTE]    = 1'b1;
          entry.mask[SLOT_ZERO_B]  = 1'b1;
          if (left_r == 8'd0) begin
            entry.mask[SLOT_END_REL] = 1'b1;
            entry.mask[SLOT_DELAY]   = 1'b1;
            phase_nxt = PH_COUNT;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        default: begin
          entry.mask[SLOT_BYTE] = 1'b1;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            entry.mask[SLOT_END_REL] = 1'b1;
            entry.mask[SLOT_DELAY]   = 1'b1;
            phase_nxt = PH_COUNT;
          end
        end
      endcase
    end
  end

  assign push = accept && (entry.mask != '0);

endmodule

### rtl/pisp_queue.sv
// small fifo of classified entries between front and back end
module pisp_queue import pisp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
    else $error("queue pop while empty");
`endif

endmodule

### rtl/pisp_back.sv
// back end: expands queued entries into result transactions
module pisp_back import pisp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] command_word,
  input  logic        head_valid,
  input  q_entry_t    head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_word,
  output logic [10:0] out_delay,
  output logic        out_last
);

  logic [NSLOT-1:0] mask_r, mask_nxt;
  logic [7:0]       byte_r;
  logic [10:0]      delay_r;
  logic             valid_r, valid_nxt;
  kind_t            kind_r;
  logic [31:0]      word_r;
  logic [10:0]      odly_r;
  logic             last_r;

  logic [NSLOT-1:0] sel_oh, rest;
  slot_t            sel;
  kind_t            kind_c;
  logic [31:0]      word_c;
  logic [10:0]      dly_c;
  logic             have, emit, load;

  always_comb begin
    sel = SLOT_ONE_LINE;
    for (int i = NSLOT-1; i >= 0; i--) begin
      if (mask_r[i]) sel = slot_t'(i);
    end
  end

  always_comb begin
    kind_c = KIND_WORD;
    word_c = 32'd0;
    dly_c  = 11'd0;
    case (sel)
      SLOT_ONE_LINE:  kind_c = KIND_ONE_LINE;
      SLOT_FOUR_LINE: kind_c = KIND_FOUR_LINE;
      SLOT_REG_REL:   word_c = RELEASE_WORD;
      SLOT_CMD:       word_c = command_word;
      SLOT_BYTE:      word_c = {24'd0, byte_r};
      SLOT_END_REL:   word_c = RELEASE_WORD;
      SLOT_DELAY: begin
        kind_c = KIND_DELAY;
        dly_c  = delay_r;
      end
      default:        word_c = 32'd0;
    endcase
  end

  assign sel_oh    = mask_r & (~mask_r + NSLOT'(1));
  assign rest      = mask_r & ~sel_oh;
  assign have      = (mask_r != '0);
  assign emit      = have && (!valid_r || out_ready);
  assign load      = head_valid && (!have || (emit && rest == '0));
  assign pop       = load;
  assign valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_comb begin
    if (load)      mask_nxt = head_entry.mask;
    else if (emit) mask_nxt = rest;
    else           mask_nxt = mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= head_entry.data_byte;
      delay_r <= head_entry.delay_ms;
    end
    if (emit) begin
      kind_r <= kind_c;
      word_r <= word_c;
      odly_r <= dly_c;
      last_r <= (rest == '0);
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_word  = word_r;
  assign out_delay = odly_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_word_only_for_words: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_WORD) |-> (word_r == 32'd0))
    else $error("serial word set on a non-word result");
  a_delay_only_for_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_DELAY) |-> (odly_r == 11'd0))
    else $error("delay set on a non-delay result");
`endif

endmodule

### rtl/panel_init_sequence_player_core.sv
// top level of the panel init sequence player: front end, queue, back end
// path: an accepted table byte's entry goes into the queue, then the back end's mask register, then the output register
// throughput: one table byte per cycle while the four-entry queue has room
// results leave at one per cycle from the back end's slot expander while out_tready is high, up to seven per byte
// reset: synchronous active-low rst_n; parser to count-byte phase at table start
// reset also empties queue and output register and clears command_word to zero
module panel_init_sequence_player_core import pisp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // config register: command_word
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] table_byte
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] serial_word, [42:32] delay_ms, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  logic [31:0] command_word_r;
  logic        q_full, q_push, q_pop, q_head_valid;
  q_entry_t    q_push_entry, q_head_entry;
  logic [31:0] res_word;
  logic [10:0] res_delay;

  // command word register; the user must write it only while the block is idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) command_word_r <= 32'd0;
    else if (cfg_wr_en) command_word_r <= cfg_wr_data;
  end

  // front end takes a byte whenever the queue can hold its entry
  assign in_tready = !q_full;

  pisp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_tvalid && in_tready),
    .table_byte (in_tdata),
    .push       (q_push),
    .entry      (q_push_entry)
  );

  // decouples the parser from bursts on the result side
  pisp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  // back end walks each entry's result mask, one transaction per cycle while out_tready is high
  pisp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .command_word (command_word_r),
    .head_valid   (q_head_valid),
    .head_entry   (q_head_entry),
    .pop          (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_word     (res_word),
    .out_delay    (res_delay),
    .out_last     (out_tlast)
  );

  assign out_tdata = {5'd0, res_delay, res_word};

endmodule

### dv/tb_panel_init_sequence_player_core.sv
// self-checking testbench for the panel init sequence player core
`timescale 1ns / 1ps

module tb_panel_init_sequence_player_core;
  import pisp_pkg::*;

  // run sizing
  localparam int ITEM_TARGET  = 400;     // table bytes to send before stopping
  localparam int SETTLE       = 8;       // quiet cycles after the last result
  localparam int HOLD_CYCLES  = 200;     // long receiver hold-off for the backpressure test
  localparam int LIMIT_CYCLES = 400000;  // watchdog, far above the slowest correct run
  localparam int PRINT_CAP    = 40;      // mismatch lines printed, all are counted

  // one expected result transaction
  typedef struct {
    kind_t       kind;
    logic [31:0] word;
    logic [10:0] delay_ms;
    logic        last;
  } panel_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  panel_init_sequence_player_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // expected results in emission order, oldest at the front
  panel_result_t pending_results[$];
  panel_result_t head_result;

  // shadow of the parser state and the command word register
  phase_t      parse_phase    = PH_COUNT;
  bit          at_table_start = 1'b1;
  logic [7:0]  data_left      = 8'h00;
  logic [7:0]  held_delay     = 8'h00;
  logic [31:0] command_word   = 32'h0;

  // bookkeeping
  int  mismatches     = 0;
  int  results_seen   = 0;
  int  items_sent     = 0;
  int  tables_closed  = 0;
  int  command_writes = 0;
  int  holds_done     = 0;
  int  cycle_count    = 0;
  bit  steady         = 1'b0;  // when set neither side idles at random
  logic hold_start    = 1'b0;  // one-cycle request for a long receiver hold-off
  int  hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // table parser shadow: works out the results one table byte causes
  // ---------------------------------------------------------------------------
  function automatic void push_result(input kind_t kind, input logic [31:0] word,
                                      input logic [10:0] delay_ms);
    panel_result_t r;
    r.kind     = kind;
    r.word     = word;
    r.delay_ms = delay_ms;
    r.last     = 1'b0;
    pending_results.push_back(r);
  endfunction

  // release word plus the held delay, back to waiting for a count byte
  function automatic void close_entry();
    logic [10:0] wait_ms;
    wait_ms = {3'b000, held_delay} * 11'd5;
    push_result(KIND_WORD, RELEASE_WORD, 11'd0);
    push_result(KIND_DELAY, 32'h0, wait_ms);
    parse_phase = PH_COUNT;
  endfunction

  function automatic void predict_table_byte(input logic [7:0] b);
    int first;
    first = pending_results.size();
    case (parse_phase)
      PH_COUNT: begin
        if (at_table_start) push_result(KIND_ONE_LINE, 32'h0, 11'd0);
        if (b == 8'h00) begin
          // zero count closes the table, the next count opens a new one
          push_result(KIND_FOUR_LINE, 32'h0, 11'd0);
          at_table_start = 1'b1;
          tables_closed++;
        end else begin
          at_table_start = 1'b0;
          data_left      = b - 8'd1;
          parse_phase    = PH_DELAY;
        end
      end
      PH_DELAY: begin
        // delay byte is held until the entry ends
        held_delay  = b;
        parse_phase = PH_REG;
      end
      PH_REG: begin
        push_result(KIND_WORD, RELEASE_WORD, 11'd0);
        push_result(KIND_WORD, command_word, 11'd0);
        push_result(KIND_WORD, 32'h0, 11'd0);
        push_result(KIND_WORD, {24'h0, b}, 11'd0);
        push_result(KIND_WORD, 32'h0, 11'd0);
        if (data_left == 8'h00) close_entry();
        else parse_phase = PH_DATA;
      end
      default: begin
        push_result(KIND_WORD, {24'h0, b}, 11'd0);
        data_left = data_left - 8'd1;
        if (data_left == 8'h00) close_entry();
      end
    endcase
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern, hold-off and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH result %0d at %0t: %s got 0x%0h want 0x%0h",
               results_seen, $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // receiver: random stalls, or a long hold-off counted here when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_start) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  // every accepted result is compared with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 48'h0);
      end else begin
        head_result = pending_results.pop_front();
        check_field("kind", 48'(out_tuser), 48'(head_result.kind));
        check_field("serial_word", 48'(out_tdata[31:0]), 48'(head_result.word));
        check_field("delay_ms", 48'(out_tdata[42:32]), 48'(head_result.delay_ms));
        check_field("tdata padding", 48'(out_tdata[47:43]), 48'h0);
        check_field("last", 48'(out_tlast), 48'(head_result.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // offer one table byte, with random gaps first; valid stays up for a
  // following byte, callers that pause drop it through wait_for_results
  task automatic send_table_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_table_byte(b);
    items_sent++;
  endtask

  // one entry: count, delay, register and count-1 random data bytes
  task automatic send_entry(input logic [7:0] cnt, input logic [7:0] dly,
                            input logic [7:0] reg_byte);
    int i;
    send_table_byte(cnt);
    send_table_byte(dly);
    send_table_byte(reg_byte);
    for (i = 1; i < int'(cnt); i++) send_table_byte(8'($urandom_range(0, 255)));
  endtask

  // sender pause: drop valid, let every expected result arrive, then settle
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // the register is only written while the block is idle
  task automatic set_command_word(input logic [31:0] w);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    command_word  = w;
    command_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // empty table right after reset, then a second empty table
  task automatic test_empty_tables();
    send_table_byte(8'h00);
    send_table_byte(8'h00);
  endtask

  // count of one: register byte closes the entry at once, seven results;
  // delay byte at both extremes, register byte at both extremes
  task automatic test_single_byte_entries();
    send_entry(8'd1, 8'h00, 8'h00);
    send_entry(8'd1, 8'hff, 8'hff);
    send_table_byte(8'h00);
  endtask

  // entries with data bytes at the extremes, under a new command word
  task automatic test_data_entries();
    set_command_word(32'h8000_0001);
    send_table_byte(8'd3);
    send_table_byte(8'd1);
    send_table_byte(8'h2a);
    send_table_byte(8'h00);
    send_table_byte(8'hff);
    send_table_byte(8'd2);
    send_table_byte(8'd200);
    send_table_byte(8'h55);
    send_table_byte(8'haa);
    send_table_byte(8'h00);
  endtask

  // receiver holds off for a long time while the sender keeps offering,
  // so the queue fills and the input stalls
  task automatic test_receiver_hold();
    wait_for_results();
    steady     = 1'b1;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_entry(8'd1, 8'd7, 8'h11);
    send_entry(8'd3, 8'd9, 8'h3c);
    send_entry(8'd1, 8'd0, 8'hc3);
    send_table_byte(8'h00);
    steady = 1'b0;
    wait_for_results();
  endtask

  // a table of random entries, mostly short; an unclosed table lets the
  // next count byte arrive without a table start
  task automatic send_random_table(input bit closed);
    int n_entries;
    int cnt;
    int i;
    n_entries = $urandom_range(0, 4);
    for (i = 0; i < n_entries; i++) begin
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
      send_entry(8'(cnt), ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end
    if (closed) send_table_byte(8'h00);
  endtask

  // phases of random tables, each under its own command word
  task automatic test_random_tables();
    int phase_no;
    int tbl;
    int pick;
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_no % 4)
        0:       set_command_word(32'hffff_ffff);
        1:       set_command_word(32'h0000_0000);
        default: set_command_word($urandom);
      endcase
      // one phase runs without any idling on either side
      steady = (phase_no == 2);
      if (phase_no == 1) send_entry(8'($urandom_range(128, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
      for (tbl = 0; tbl < 6 && items_sent < ITEM_TARGET; tbl++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // noise, then random bytes until the parser waits for a count again
          repeat ($urandom_range(2, 6)) send_table_byte(8'($urandom_range(0, 255)));
          while (parse_phase != PH_COUNT) send_table_byte(8'($urandom_range(0, 255)));
        end else begin
          send_random_table(pick != 1);
        end
      end
      steady = 1'b0;
      phase_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tables();
    test_single_byte_entries();
    test_data_entries();
    test_receiver_hold();
    test_random_tables();

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("sent %0d table bytes, checked %0d results, closed %0d tables",
             items_sent, results_seen, tables_closed);
    $display("used %0d command word settings and %0d long receiver hold-offs",
             command_writes, holds_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### panel_init_sequence_player_core.f
rtl/pisp_pkg.sv
rtl/pisp_front.sv
rtl/pisp_queue.sv
rtl/pisp_back.sv
rtl/panel_init_sequence_player_core.sv
dv/tb_panel_init_sequence_player_core.sv
